/* hdl/pbct_pkg.sv */
// Shared types, constants and helpers of the position-independent base tracker.
package pbct_pkg;

  localparam int NUM_REGS = 32;
  localparam int IDX_W    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  typedef logic [IDX_W-1:0] idx_t;

  // Operation codes; any code not listed is handled as "other".
  localparam logic [2:0] OP_BRANCH = 3'd0;
  localparam logic [2:0] OP_MFLR   = 3'd1;
  localparam logic [2:0] OP_LIS    = 3'd2;
  localparam logic [2:0] OP_ORI    = 3'd3;
  localparam logic [2:0] OP_ADD    = 3'd4;
  localparam logic [2:0] OP_MTLR   = 3'd5;
  localparam logic [2:0] OP_OTHER  = 3'd6;

  // Status codes reported with every result item.
  localparam logic [1:0] STATUS_IDLE = 2'd0;
  localparam logic [1:0] STATUS_SEEN = 2'd1;
  localparam logic [1:0] STATUS_BASE = 2'd2;

  localparam logic [31:0] LIS_MASK  = 32'hffff0000;
  localparam int          LIS_SHIFT = 16;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_SEEN = 3'b010,
    PH_BASE = 3'b100
  } phase_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] instr_addr;
    logic [3:0]  instr_size;
    logic [31:0] target_addr;
    logic        form_ok;
    logic [4:0]  dest_reg;
    logic [4:0]  src_a_reg;
    logic [4:0]  src_b_reg;
    logic [15:0] immediate;
  } item_t;

  typedef struct packed {
    logic [1:0]  tracker_status;
    logic        note_valid;
    logic [4:0]  note_reg;
    logic [31:0] note_value;
  } result_t;

  typedef struct packed {
    logic        en;
    idx_t        idx;
    logic [31:0] data;
  } mem_wr_t;

  function automatic logic in_range(input logic [4:0] r);
    return int'(r) < NUM_REGS;
  endfunction

  function automatic idx_t to_idx(input logic [4:0] r);
    return idx_t'(r);
  endfunction

endpackage

/* hdl/pbct_regfile.sv */
// Register value store: one write port and two registered read ports.
module pbct_regfile (
  input  logic                clk,
  input  logic                rd_en,
  input  pbct_pkg::idx_t      rd_a_idx,
  input  pbct_pkg::idx_t      rd_b_idx,
  output logic [31:0]         rd_a_data,
  output logic [31:0]         rd_b_data,
  input  pbct_pkg::mem_wr_t   wr
);
  import pbct_pkg::*;

  logic [31:0] mem [NUM_REGS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
  end

  // Reads return the contents from before a write at the same edge.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_data <= mem[rd_a_idx];
      rd_b_data <= mem[rd_b_idx];
    end
  end

endmodule

/* hdl/pbct_core.sv */
// Tracker state, known bits, write-back forwarding and the per-item decision logic.
module pbct_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic                fire,
  input  pbct_pkg::item_t     item,
  input  logic [31:0]         rd_a_data,
  input  logic [31:0]         rd_b_data,
  output pbct_pkg::mem_wr_t   wr,
  output pbct_pkg::result_t   res
);
  import pbct_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [4:0]          base_reg_r, base_reg_nxt;
  logic [31:0]         base_addr_r, base_addr_nxt;
  logic [NUM_REGS-1:0] known_r, known_nxt;
  logic                fwd_valid_r;
  idx_t                fwd_idx_r;
  logic [31:0]         fwd_data_r;

  logic        clr;
  logic        wr_req;
  logic [4:0]  wr_reg;
  logic [31:0] wr_val;
  logic        mark_unknown;
  logic        known_a, known_b;
  logic [31:0] val_a, val_b, sum;

  // The memory read happened when this item was taken; a write made at that
  // same edge is picked up from the forwarding register.
  always_comb begin
    val_a = (fwd_valid_r && fwd_idx_r == to_idx(item.src_a_reg)) ? fwd_data_r : rd_a_data;
    val_b = (fwd_valid_r && fwd_idx_r == to_idx(item.src_b_reg)) ? fwd_data_r : rd_b_data;
    known_a = in_range(item.src_a_reg) && known_r[to_idx(item.src_a_reg)];
    known_b = in_range(item.src_b_reg) && known_r[to_idx(item.src_b_reg)];
    sum = val_a + val_b;
  end

  always_comb begin
    phase_nxt     = phase_r;
    base_reg_nxt  = base_reg_r;
    base_addr_nxt = base_addr_r;
    known_nxt     = known_r;
    clr           = 1'b0;
    wr_req        = 1'b0;
    wr_reg        = item.dest_reg;
    wr_val        = '0;
    mark_unknown  = 1'b0;
    res.note_valid = 1'b0;
    res.note_reg   = '0;
    res.note_value = '0;

    case (phase_r)
      PH_IDLE: begin
        if (item.operation == OP_BRANCH && item.form_ok &&
            item.target_addr == item.instr_addr + 32'(item.instr_size)) begin
          phase_nxt     = PH_SEEN;
          base_addr_nxt = item.target_addr;
        end
      end
      PH_SEEN: begin
        if (item.operation == OP_MFLR && item.form_ok) begin
          base_reg_nxt = item.dest_reg;
          phase_nxt    = PH_BASE;
          wr_req       = 1'b1;
          wr_val       = base_addr_r;
        end else begin
          clr = 1'b1;
        end
      end
      PH_BASE: begin
        case (item.operation)
          OP_ADD: begin
            if (item.src_a_reg == base_reg_r || item.src_b_reg == base_reg_r) begin
              if (known_a && known_b) begin
                wr_req         = 1'b1;
                wr_val         = sum;
                res.note_valid = 1'b1;
                res.note_reg   = item.dest_reg;
                res.note_value = sum;
              end else begin
                clr = 1'b1;
              end
            end else if (item.dest_reg == base_reg_r) begin
              clr = 1'b1;
            end
          end
          OP_LIS: begin
            if (item.dest_reg == base_reg_r) begin
              clr = 1'b1;
            end else begin
              wr_req = 1'b1;
              wr_val = ({16'd0, item.immediate} << LIS_SHIFT) & LIS_MASK;
            end
          end
          OP_ORI: begin
            if (item.dest_reg == base_reg_r) begin
              clr = 1'b1;
            end else if (item.dest_reg == item.src_a_reg) begin
              if (known_a) begin
                wr_req = 1'b1;
                wr_val = val_a | {16'd0, item.immediate};
              end
            end else begin
              mark_unknown = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    if (clr) begin
      phase_nxt    = PH_IDLE;
      base_reg_nxt = '0;
      known_nxt    = '0;
    end
    if (wr_req && in_range(wr_reg)) begin
      known_nxt[to_idx(wr_reg)] = 1'b1;
    end
    if (mark_unknown && in_range(item.dest_reg)) begin
      known_nxt[to_idx(item.dest_reg)] = 1'b0;
    end

    wr.en   = fire && wr_req && in_range(wr_reg);
    wr.idx  = to_idx(wr_reg);
    wr.data = wr_val;

    case (phase_nxt)
      PH_IDLE: res.tracker_status = STATUS_IDLE;
      PH_SEEN: res.tracker_status = STATUS_SEEN;
      PH_BASE: res.tracker_status = STATUS_BASE;
      default: res.tracker_status = STATUS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      base_reg_r  <= '0;
      base_addr_r <= '0;
      known_r     <= '0;
      fwd_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r     <= phase_nxt;
        base_reg_r  <= base_reg_nxt;
        base_addr_r <= base_addr_nxt;
        known_r     <= known_nxt;
      end
      if (rd_en) begin
        fwd_valid_r <= wr.en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_idx_r  <= wr.idx;
      fwd_data_r <= wr.data;
    end
  end

endmodule

/* hdl/pic_base_constant_tracker.sv */
// Top level of the position-independent base tracker with its item handshakes.
// A taken item is held in stage one, then its result item is registered in the output register.
// One item per cycle while out_ready does not stall the output register.
// A write made by one item is forwarded to the item read at the same edge.
// Reset (synchronous, rst_n low) returns the tracker to idle with all registers unknown.
// No clearing pass: known bits are flip-flops cleared at once, so items are taken at once.
module pic_base_constant_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_instr_addr,
  input  logic [3:0]  in_instr_size,
  input  logic [31:0] in_target_addr,
  input  logic        in_form_ok,
  input  logic [4:0]  in_dest_reg,
  input  logic [4:0]  in_src_a_reg,
  input  logic [4:0]  in_src_b_reg,
  input  logic [15:0] in_immediate,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_tracker_status,
  output logic        out_note_valid,
  output logic [4:0]  out_note_reg,
  output logic [31:0] out_note_value
);
  import pbct_pkg::*;

  // Stage one holds the item whose register-file read is in flight; the
  // output register holds a finished result while the next item is worked on.
  logic      s1_valid_r, s1_valid_nxt;
  item_t     s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  result_t   out_res_r;

  logic      in_accept;
  logic      fire;
  logic [31:0] rd_a_data, rd_b_data;
  mem_wr_t   wr;
  result_t   res;

  // An item in stage one moves on when the output register is free or emptying.
  // No item is taken while reset is held.
  assign fire      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = rst_n && (!s1_valid_r || fire);
  assign in_accept = in_valid && in_ready;

  assign s1_valid_nxt  = in_accept || (s1_valid_r && !fire);
  assign out_valid_nxt = fire || (out_valid_r && !out_ready);

  pbct_regfile u_regfile (
    .clk       (clk),
    .rd_en     (in_accept),
    .rd_a_idx  (to_idx(in_src_a_reg)),
    .rd_b_idx  (to_idx(in_src_b_reg)),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data),
    .wr        (wr)
  );

  pbct_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_accept),
    .fire      (fire),
    .item      (s1_item_r),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data),
    .wr        (wr),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r.operation   <= in_operation;
      s1_item_r.instr_addr  <= in_instr_addr;
      s1_item_r.instr_size  <= in_instr_size;
      s1_item_r.target_addr <= in_target_addr;
      s1_item_r.form_ok     <= in_form_ok;
      s1_item_r.dest_reg    <= in_dest_reg;
      s1_item_r.src_a_reg   <= in_src_a_reg;
      s1_item_r.src_b_reg   <= in_src_b_reg;
      s1_item_r.immediate   <= in_immediate;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tracker_status = out_res_r.tracker_status;
  assign out_note_valid     = out_res_r.note_valid;
  assign out_note_reg       = out_res_r.note_reg;
  assign out_note_value     = out_res_r.note_value;

endmodule
